FILE: rtl/lsqd_pkg.sv
`timescale 1ns / 1ps

package lsqd_pkg;

	// queue depths and derived widths
	localparam int LOAD_DEPTH  = 32;
	localparam int STORE_DEPTH = 32;
	localparam int LCNT_W      = $clog2(LOAD_DEPTH + 1);
	localparam int SCNT_W      = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W       = ((LCNT_W > SCNT_W) ? LCNT_W : SCNT_W) + 1;
	localparam int CMP_W       = (SUM_W > 7) ? SUM_W : 7;
	localparam int CFG_AW      = 4;

	// request codes
	typedef logic [2:0] req_t;
	localparam req_t REQ_ADD_LOAD     = 3'd0;
	localparam req_t REQ_ADD_STORE    = 3'd1;
	localparam req_t REQ_LOAD_READY   = 3'd2;
	localparam req_t REQ_MARK_FLUSH   = 3'd3;
	localparam req_t REQ_PURGE        = 3'd4;
	localparam req_t REQ_COMMIT_LOAD  = 3'd5;
	localparam req_t REQ_COMMIT_STORE = 3'd6;

	// status codes
	typedef logic [2:0] stat_t;
	localparam stat_t STAT_OK        = 3'd0;
	localparam stat_t STAT_FULL      = 3'd1;
	localparam stat_t STAT_EMPTY     = 3'd2;
	localparam stat_t STAT_NOT_HEAD  = 3'd3;
	localparam stat_t STAT_NOT_FOUND = 3'd4;

	// register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_COMBINED_MODE = 2'd0;
	localparam reg_idx_t REG_COMBINED_CAP  = 2'd1;
	localparam reg_idx_t REG_LOAD_CAP      = 2'd2;
	localparam reg_idx_t REG_STORE_CAP     = 2'd3;

	// broadcast cell operations
	typedef logic [2:0] cell_op_t;
	localparam cell_op_t OP_NONE    = 3'd0;
	localparam cell_op_t OP_ADD     = 3'd1;
	localparam cell_op_t OP_POP     = 3'd2;
	localparam cell_op_t OP_FLUSH   = 3'd3;
	localparam cell_op_t OP_COMPACT = 3'd4;

	// what a walking token does at a cell
	typedef logic [1:0] scan_t;
	localparam scan_t SCAN_READY = 2'd0;
	localparam scan_t SCAN_VIOL  = 2'd1;
	localparam scan_t SCAN_DROP  = 2'd2;

	typedef struct packed {
		logic [63:0] tag;
		logic [63:0] addr;
		logic [7:0]  len;
		logic        ready;
		logic        flushed;
	} entry_t;

	typedef struct packed {
		cell_op_t    op;
		scan_t       mode;
		logic [63:0] tag;
		logic [63:0] addr;
		logic [7:0]  len;
		logic [63:0] st_addr;
		logic [64:0] st_end;
	} cell_cmd_t;

endpackage

FILE: rtl/lsqd_if.sv
`timescale 1ns / 1ps

// request channel
interface lsqd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [63:0] seq_tag;
	logic [63:0] access_addr;
	logic [7:0]  access_bytes;

	modport source (output valid, req_type, seq_tag, access_addr, access_bytes, input ready);
	modport sink (input valid, req_type, seq_tag, access_addr, access_bytes, output ready);
endinterface

// result channel
interface lsqd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        violation;
	logic [63:0] violating_tag;
	logic [6:0]  load_space;
	logic [6:0]  store_space;
	logic [6:0]  total_space;

	modport source (output valid, status, violation, violating_tag, load_space, store_space,
		total_space, input ready);
	modport sink (input valid, status, violation, violating_tag, load_space, store_space,
		total_space, output ready);
endinterface

FILE: rtl/load_store_queue_disambiguation_unit.sv
`timescale 1ns / 1ps

// Load/store queue with memory-order violation check.
// req carries one request beat (add load/store, load ready, mark flushed,
// purge, commit load, commit store); rsp returns one result beat per request
// with status, violation flag, last violating tag and free-space counts.
// Registers are written over the APB port; pready is always high.
// Both queues are rows of cells; a request is taken in the idle state and
// executed in the next cycle. Add, mark flushed and commit load answer from
// the execute state through the output register. Load ready and a successful
// commit store walk a token down the load row one cell a cycle. Purge walks
// both rows and then closes the gaps one cell a cycle. One request is in
// flight at a time. Reset empties both queues, clears the violating tag and
// restores the register defaults. A result waits in the output register
// while rsp is stalled; req.ready stays low until that result is taken.
module load_store_queue_disambiguation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	lsqd_req_if.sink                      req,
	lsqd_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsqd_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_SCAN    = 2'd2;
	localparam logic [1:0] S_COMPACT = 2'd3;

	localparam int LD = lsqd_pkg::LOAD_DEPTH;
	localparam int SD = lsqd_pkg::STORE_DEPTH;
	localparam int LW = lsqd_pkg::LCNT_W;
	localparam int SW = lsqd_pkg::SCNT_W;
	localparam int UW = lsqd_pkg::SUM_W;
	localparam int CW = lsqd_pkg::CMP_W;

	logic [1:0]             state_q, state_d;
	lsqd_pkg::req_t         type_q;
	logic [63:0]            tag_q, addr_q;
	logic [7:0]             len_q;
	logic [LW-1:0]          ld_cnt_q, ld_cnt_d;
	logic [SW-1:0]          st_cnt_q, st_cnt_d;
	lsqd_pkg::scan_t        mode_q, mode_d;
	logic                   found_q, found_d;
	logic [63:0]            last_viol_q, last_viol_d;
	logic [63:0]            st_addr_q, st_addr_d;
	logic [64:0]            st_end_q, st_end_d;
	logic                   out_valid_q, out_valid_d;
	lsqd_pkg::stat_t        out_status_q, out_status_d;
	logic                   out_viol_q, out_viol_d;
	logic                   comb_mode_q;
	logic [6:0]             comb_cap_q;
	logic [5:0]             load_cap_q, store_cap_q;

	lsqd_pkg::cell_cmd_t    ld_cmd, st_cmd;
	lsqd_pkg::cell_op_t     ld_op, st_op;
	logic                   ld_tok0, st_tok0;
	lsqd_pkg::entry_t       ld_ent [LD];
	lsqd_pkg::entry_t       st_ent [SD];
	logic [LD-1:0]          ld_valid, ld_tok, ld_tout, ld_hit, ld_match, ld_fl;
	logic [SD-1:0]          st_valid, st_tok, st_tout, st_hit, st_match, st_fl;
	logic [63:0]            hit_tag;
	logic                   accept;
	logic                   full;
	logic [UW-1:0]          cnt_sum;
	logic [6:0]             comb_sp, ld_sp, st_sp;
	logic                   cfg_wr;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign cnt_sum   = UW'(ld_cnt_q) + UW'(st_cnt_q);

	// broadcast commands
	always_comb begin
		ld_cmd.op      = ld_op;
		ld_cmd.mode    = mode_q;
		ld_cmd.tag     = tag_q;
		ld_cmd.addr    = addr_q;
		ld_cmd.len     = len_q;
		ld_cmd.st_addr = st_addr_q;
		ld_cmd.st_end  = st_end_q;
		st_cmd         = ld_cmd;
		st_cmd.op      = st_op;
	end

	// load row
	for (genvar i = 0; i < LD; i++) begin : g_ld
		logic             pv, nv;
		lsqd_pkg::entry_t ne;
		logic             ti;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
			assign ti = ld_tok0;
		end else begin : g_mid
			assign pv = ld_valid[i-1];
			assign ti = ld_tout[i-1];
		end
		if (i == LD - 1) begin : g_last
			assign nv = 1'b0;
			assign ne = '0;
		end else begin : g_next
			assign nv = ld_valid[i+1];
			assign ne = ld_ent[i+1];
		end
		lsqd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(ld_cmd), .prev_valid(pv), .next_valid(nv),
			.next_ent(ne), .token_in(ti), .ent(ld_ent[i]), .valid(ld_valid[i]),
			.token(ld_tok[i]), .token_out(ld_tout[i]), .hit(ld_hit[i]), .match(ld_match[i])
		);
		assign ld_fl[i] = ld_ent[i].flushed;
	end

	// store row
	for (genvar i = 0; i < SD; i++) begin : g_st
		logic             pv, nv;
		lsqd_pkg::entry_t ne;
		logic             ti;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
			assign ti = st_tok0;
		end else begin : g_mid
			assign pv = st_valid[i-1];
			assign ti = st_tout[i-1];
		end
		if (i == SD - 1) begin : g_last
			assign nv = 1'b0;
			assign ne = '0;
		end else begin : g_next
			assign nv = st_valid[i+1];
			assign ne = st_ent[i+1];
		end
		lsqd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(st_cmd), .prev_valid(pv), .next_valid(nv),
			.next_ent(ne), .token_in(ti), .ent(st_ent[i]), .valid(st_valid[i]),
			.token(st_tok[i]), .token_out(st_tout[i]), .hit(st_hit[i]), .match(st_match[i])
		);
		assign st_fl[i] = st_ent[i].flushed;
	end

	// tag of the load the token stopped at
	always_comb begin
		hit_tag = '0;
		for (int i = 0; i < LD; i++)
			if (ld_hit[i])
				hit_tag = hit_tag | ld_ent[i].tag;
	end

	// capacity check for an add
	always_comb begin
		if (comb_mode_q)
			full = CW'(cnt_sum) >= CW'(comb_cap_q);
		else if (type_q == lsqd_pkg::REQ_ADD_LOAD)
			full = CW'(ld_cnt_q) >= CW'(load_cap_q);
		else
			full = CW'(st_cnt_q) >= CW'(store_cap_q);
		if (type_q == lsqd_pkg::REQ_ADD_LOAD && ld_cnt_q >= LW'(LD))
			full = 1'b1;
		if (type_q == lsqd_pkg::REQ_ADD_STORE && st_cnt_q >= SW'(SD))
			full = 1'b1;
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		ld_cnt_d     = ld_cnt_q;
		st_cnt_d     = st_cnt_q;
		mode_d       = mode_q;
		found_d      = found_q;
		last_viol_d  = last_viol_q;
		st_addr_d    = st_addr_q;
		st_end_d     = st_end_q;
		out_valid_d  = out_valid_q && !rsp.ready;
		out_status_d = out_status_q;
		out_viol_d   = out_viol_q;
		ld_op        = lsqd_pkg::OP_NONE;
		st_op        = lsqd_pkg::OP_NONE;
		ld_tok0      = 1'b0;
		st_tok0      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d      = S_IDLE;
				out_valid_d  = 1'b1;
				out_status_d = lsqd_pkg::STAT_OK;
				out_viol_d   = 1'b0;
				found_d      = 1'b0;
				case (type_q)
					lsqd_pkg::REQ_ADD_LOAD, lsqd_pkg::REQ_ADD_STORE: begin
						if (full) begin
							out_status_d = lsqd_pkg::STAT_FULL;
						end else if (type_q == lsqd_pkg::REQ_ADD_LOAD) begin
							ld_op    = lsqd_pkg::OP_ADD;
							ld_cnt_d = ld_cnt_q + LW'(1);
						end else begin
							st_op    = lsqd_pkg::OP_ADD;
							st_cnt_d = st_cnt_q + SW'(1);
						end
					end
					lsqd_pkg::REQ_LOAD_READY: begin
						ld_tok0     = 1'b1;
						mode_d      = lsqd_pkg::SCAN_READY;
						out_valid_d = 1'b0;
						state_d     = S_SCAN;
					end
					lsqd_pkg::REQ_MARK_FLUSH: begin
						ld_op = lsqd_pkg::OP_FLUSH;
						st_op = lsqd_pkg::OP_FLUSH;
						if (!(|ld_match) && !(|st_match))
							out_status_d = lsqd_pkg::STAT_NOT_FOUND;
					end
					lsqd_pkg::REQ_PURGE: begin
						ld_tok0     = 1'b1;
						st_tok0     = 1'b1;
						mode_d      = lsqd_pkg::SCAN_DROP;
						out_valid_d = 1'b0;
						state_d     = S_SCAN;
					end
					lsqd_pkg::REQ_COMMIT_LOAD: begin
						if (!ld_valid[0]) begin
							out_status_d = lsqd_pkg::STAT_EMPTY;
						end else if (ld_ent[0].tag != tag_q) begin
							out_status_d = lsqd_pkg::STAT_NOT_HEAD;
						end else begin
							ld_op    = lsqd_pkg::OP_POP;
							ld_cnt_d = ld_cnt_q - LW'(1);
						end
					end
					lsqd_pkg::REQ_COMMIT_STORE: begin
						if (!st_valid[0]) begin
							out_status_d = lsqd_pkg::STAT_EMPTY;
						end else if (st_ent[0].tag != tag_q) begin
							out_status_d = lsqd_pkg::STAT_NOT_HEAD;
						end else begin
							st_op       = lsqd_pkg::OP_POP;
							st_cnt_d    = st_cnt_q - SW'(1);
							st_addr_d   = st_ent[0].addr;
							st_end_d    = {1'b0, st_ent[0].addr} + 65'(st_ent[0].len);
							ld_tok0     = 1'b1;
							mode_d      = lsqd_pkg::SCAN_VIOL;
							out_valid_d = 1'b0;
							state_d     = S_SCAN;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (|ld_hit) begin
					found_d = 1'b1;
					if (mode_q == lsqd_pkg::SCAN_VIOL)
						last_viol_d = hit_tag;
				end
				if (|(ld_tok & ld_valid & ld_fl) && mode_q == lsqd_pkg::SCAN_DROP)
					ld_cnt_d = ld_cnt_q - LW'(1);
				if (|(st_tok & st_valid & st_fl) && mode_q == lsqd_pkg::SCAN_DROP)
					st_cnt_d = st_cnt_q - SW'(1);
				if (!(|ld_tok) && !(|st_tok)) begin
					if (mode_q == lsqd_pkg::SCAN_DROP) begin
						state_d = S_COMPACT;
					end else begin
						state_d      = S_IDLE;
						out_valid_d  = 1'b1;
						out_viol_d   = (mode_q == lsqd_pkg::SCAN_VIOL) && found_q;
						out_status_d = (mode_q == lsqd_pkg::SCAN_READY && !found_q) ?
							lsqd_pkg::STAT_NOT_FOUND : lsqd_pkg::STAT_OK;
					end
				end
			end
			S_COMPACT: begin
				ld_op = lsqd_pkg::OP_COMPACT;
				st_op = lsqd_pkg::OP_COMPACT;
				if (!(|(ld_valid[LD-1:1] & ~ld_valid[LD-2:0])) &&
					!(|(st_valid[SD-1:1] & ~st_valid[SD-2:0]))) begin
					state_d      = S_IDLE;
					out_valid_d  = 1'b1;
					out_status_d = lsqd_pkg::STAT_OK;
					out_viol_d   = 1'b0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ld_cnt_q    <= '0;
			st_cnt_q    <= '0;
			mode_q      <= lsqd_pkg::SCAN_READY;
			found_q     <= 1'b0;
			last_viol_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ld_cnt_q    <= ld_cnt_d;
			st_cnt_q    <= st_cnt_d;
			mode_q      <= mode_d;
			found_q     <= found_d;
			last_viol_q <= last_viol_d;
			out_valid_q <= out_valid_d;
		end
	end

	// request latch and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			tag_q  <= req.seq_tag;
			addr_q <= req.access_addr;
			len_q  <= req.access_bytes;
		end
		st_addr_q    <= st_addr_d;
		st_end_q     <= st_end_d;
		out_status_q <= out_status_d;
		out_viol_q   <= out_viol_d;
	end

	// free space, saturating at zero
	always_comb begin
		comb_sp = (CW'(comb_cap_q) > CW'(cnt_sum)) ? 7'(CW'(comb_cap_q) - CW'(cnt_sum)) : 7'd0;
		ld_sp   = (CW'(load_cap_q) > CW'(ld_cnt_q)) ? 7'(CW'(load_cap_q) - CW'(ld_cnt_q)) : 7'd0;
		st_sp   = (CW'(store_cap_q) > CW'(st_cnt_q)) ? 7'(CW'(store_cap_q) - CW'(st_cnt_q)) : 7'd0;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.violation     = out_viol_q;
	assign rsp.violating_tag = last_viol_q;
	assign rsp.load_space    = comb_mode_q ? comb_sp : ld_sp;
	assign rsp.store_space   = comb_mode_q ? comb_sp : st_sp;
	assign rsp.total_space   = comb_mode_q ? comb_sp : 7'(ld_sp + st_sp);

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_mode_q <= 1'b1;
			comb_cap_q  <= 7'd32;
			load_cap_q  <= 6'd16;
			store_cap_q <= 6'd16;
		end else if (cfg_wr) begin
			unique case (lsqd_pkg::reg_idx_t'(paddr[3:2]))
				lsqd_pkg::REG_COMBINED_MODE: comb_mode_q <= pwdata[0];
				lsqd_pkg::REG_COMBINED_CAP:  comb_cap_q  <= pwdata[6:0];
				lsqd_pkg::REG_LOAD_CAP:      load_cap_q  <= pwdata[5:0];
				lsqd_pkg::REG_STORE_CAP:     store_cap_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (lsqd_pkg::reg_idx_t'(paddr[3:2]))
			lsqd_pkg::REG_COMBINED_MODE: prdata = {31'd0, comb_mode_q};
			lsqd_pkg::REG_COMBINED_CAP:  prdata = {25'd0, comb_cap_q};
			lsqd_pkg::REG_LOAD_CAP:      prdata = {26'd0, load_cap_q};
			lsqd_pkg::REG_STORE_CAP:     prdata = {26'd0, store_cap_q};
			default:                     prdata = '0;
		endcase
	end

endmodule

FILE: rtl/lsqd_cell.sv
`timescale 1ns / 1ps

module lsqd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lsqd_pkg::cell_cmd_t cmd,
	input  logic               prev_valid,
	input  logic               next_valid,
	input  lsqd_pkg::entry_t   next_ent,
	input  logic               token_in,
	output lsqd_pkg::entry_t   ent,
	output logic               valid,
	output logic               token,
	output logic               token_out,
	output logic               hit,
	output logic               match
);

	lsqd_pkg::entry_t ent_q, ent_d;
	logic             valid_q, valid_d;
	logic             token_q;
	logic [64:0]      own_end;
	logic             overlap;
	logic             sel;

	// tag compare and byte-range overlap against the committing store
	always_comb begin
		match   = valid_q && (ent_q.tag == cmd.tag);
		own_end = {1'b0, ent_q.addr} + 65'(ent_q.len);
		overlap = !((own_end <= {1'b0, cmd.st_addr}) || (cmd.st_end <= {1'b0, ent_q.addr}));
		case (cmd.mode)
			lsqd_pkg::SCAN_READY: sel = match;
			lsqd_pkg::SCAN_VIOL:  sel = valid_q && ent_q.ready && overlap;
			default:              sel = 1'b0;
		endcase
		hit       = token_q && sel;
		token_out = token_q && valid_q && !sel;
	end

	// entry update
	always_comb begin
		ent_d   = ent_q;
		valid_d = valid_q;
		case (cmd.op)
			lsqd_pkg::OP_ADD: begin
				if (!valid_q && prev_valid) begin
					ent_d.tag     = cmd.tag;
					ent_d.addr    = cmd.addr;
					ent_d.len     = cmd.len;
					ent_d.ready   = 1'b0;
					ent_d.flushed = 1'b0;
					valid_d       = 1'b1;
				end
			end
			lsqd_pkg::OP_POP: begin
				ent_d   = next_ent;
				valid_d = next_valid;
			end
			lsqd_pkg::OP_FLUSH: begin
				if (match)
					ent_d.flushed = 1'b1;
			end
			lsqd_pkg::OP_COMPACT: begin
				if (!valid_q && next_valid) begin
					ent_d   = next_ent;
					valid_d = 1'b1;
				end else if (valid_q && !prev_valid) begin
					valid_d = 1'b0;
				end
			end
			default: begin
				if (token_q) begin
					if (cmd.mode == lsqd_pkg::SCAN_READY && match)
						ent_d.ready = 1'b1;
					if (cmd.mode == lsqd_pkg::SCAN_DROP && valid_q && ent_q.flushed)
						valid_d = 1'b0;
				end
			end
		endcase
	end

	// flags reset, payload holds its value through reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			token_q       <= 1'b0;
			ent_q.ready   <= 1'b0;
			ent_q.flushed <= 1'b0;
		end else begin
			valid_q <= valid_d;
			token_q <= token_in;
			ent_q   <= ent_d;
		end
	end

	assign ent   = ent_q;
	assign valid = valid_q;
	assign token = token_q;

endmodule

FILE: rtl/lsqd_checker.sv
`timescale 1ns / 1ps

module lsqd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic       violation
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(violation))
		else $error("result changed while stalled");

	// status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= lsqd_pkg::STAT_NOT_FOUND)
		else $error("status code out of range");

	// a violation only comes with an OK status
	a_viol_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && violation |-> status == lsqd_pkg::STAT_OK)
		else $error("violation with failing status");

	// no new request while a result waits
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result stalled");

	// one request in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("back-to-back request accepted");

endmodule

bind load_store_queue_disambiguation_unit lsqd_checker u_lsqd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.violation(rsp.violation)
);

FILE: tb/load_store_queue_disambiguation_unit_test.sv
`timescale 1ns / 1ps

// one request beat
typedef struct {
	lsqd_pkg::req_t op;
	logic [63:0]    tag;
	logic [63:0]    addr;
	logic [7:0]     len;
} lsq_beat_t;

// one result beat
typedef struct {
	lsqd_pkg::stat_t status;
	logic            violation;
	logic [63:0]     vtag;
	logic [6:0]      lspace;
	logic [6:0]      sspace;
	logic [6:0]      tspace;
} lsq_result_t;

// one queue entry as the predictor keeps it
typedef struct {
	logic [63:0] tag;
	logic [63:0] addr;
	logic [7:0]  len;
	bit          rdy;
	bit          fl;
} lsq_entry_t;

class lsq_scoreboard;
	lsq_entry_t  loads[$];
	lsq_entry_t  stores[$];
	logic [63:0] violator;
	bit          cmode;
	int          ccap, lcap, scap;
	lsq_result_t pending[$];
	int          errors;

	function void clear();
		loads.delete();
		stores.delete();
		pending.delete();
		violator = '0;
		cmode = 1;
		ccap = 32;
		lcap = 16;
		scap = 16;
		errors = 0;
	endfunction

	// byte ranges [addr, addr+len) with an unwrapped end
	function bit overlaps(lsq_entry_t a, lsq_entry_t b);
		logic [64:0] a_end, b_end;
		a_end = {1'b0, a.addr} + 65'(a.len);
		b_end = {1'b0, b.addr} + 65'(b.len);
		return !(a_end <= {1'b0, b.addr} || b_end <= {1'b0, a.addr});
	endfunction

	function int sat(int a, int b);
		return a > b ? a - b : 0;
	endfunction

	// predict the result of an accepted request
	function void note_request(lsq_beat_t b);
		lsq_result_t r;
		lsq_entry_t  e;
		lsq_entry_t  keep[$];
		bit          full, found;
		int          ls, ss;
		r.status = lsqd_pkg::STAT_OK;
		r.violation = 0;
		case (b.op)
			lsqd_pkg::REQ_ADD_LOAD, lsqd_pkg::REQ_ADD_STORE: begin
				if (cmode)
					full = loads.size() + stores.size() >= ccap;
				else if (b.op == lsqd_pkg::REQ_ADD_LOAD)
					full = loads.size() >= lcap;
				else
					full = stores.size() >= scap;
				if (b.op == lsqd_pkg::REQ_ADD_LOAD && loads.size() >= lsqd_pkg::LOAD_DEPTH)
					full = 1;
				if (b.op == lsqd_pkg::REQ_ADD_STORE && stores.size() >= lsqd_pkg::STORE_DEPTH)
					full = 1;
				if (full) begin
					r.status = lsqd_pkg::STAT_FULL;
				end else begin
					e.tag = b.tag;
					e.addr = b.addr;
					e.len = b.len;
					e.rdy = 0;
					e.fl = 0;
					if (b.op == lsqd_pkg::REQ_ADD_LOAD) loads.insert(loads.size(), e);
					else stores.insert(stores.size(), e);
				end
			end
			lsqd_pkg::REQ_LOAD_READY: begin
				r.status = lsqd_pkg::STAT_NOT_FOUND;
				foreach (loads[i])
					if (loads[i].tag == b.tag) begin
						loads[i].rdy = 1;
						r.status = lsqd_pkg::STAT_OK;
						break;
					end
			end
			lsqd_pkg::REQ_MARK_FLUSH: begin
				found = 0;
				foreach (loads[i])
					if (loads[i].tag == b.tag) begin
						loads[i].fl = 1;
						found = 1;
					end
				foreach (stores[i])
					if (stores[i].tag == b.tag) begin
						stores[i].fl = 1;
						found = 1;
					end
				if (!found) r.status = lsqd_pkg::STAT_NOT_FOUND;
			end
			lsqd_pkg::REQ_PURGE: begin
				keep.delete();
				foreach (loads[i]) if (!loads[i].fl) keep.insert(keep.size(), loads[i]);
				loads = keep;
				keep.delete();
				foreach (stores[i]) if (!stores[i].fl) keep.insert(keep.size(), stores[i]);
				stores = keep;
			end
			lsqd_pkg::REQ_COMMIT_LOAD: begin
				if (loads.size() == 0) r.status = lsqd_pkg::STAT_EMPTY;
				else if (loads[0].tag != b.tag) r.status = lsqd_pkg::STAT_NOT_HEAD;
				else loads.delete(0);
			end
			lsqd_pkg::REQ_COMMIT_STORE: begin
				if (stores.size() == 0) begin
					r.status = lsqd_pkg::STAT_EMPTY;
				end else if (stores[0].tag != b.tag) begin
					r.status = lsqd_pkg::STAT_NOT_HEAD;
				end else begin
					foreach (loads[i])
						if (loads[i].rdy && overlaps(stores[0], loads[i])) begin
							violator = loads[i].tag;
							r.violation = 1;
							break;
						end
					stores.delete(0);
				end
			end
			default: ;
		endcase
		if (cmode) begin
			ls = sat(ccap, loads.size() + stores.size());
			r.lspace = 7'(ls);
			r.sspace = 7'(ls);
			r.tspace = 7'(ls);
		end else begin
			ls = sat(lcap, loads.size());
			ss = sat(scap, stores.size());
			r.lspace = 7'(ls);
			r.sspace = 7'(ss);
			r.tspace = 7'(ls + ss);
		end
		r.vtag = violator;
		pending.insert(pending.size(), r);
	endfunction

	// compare a result beat with the oldest prediction
	function void check_result(lsq_result_t got);
		lsq_result_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result beat status %0d", got.status);
			return;
		end
		want = pending[0];
		pending.delete(0);
		if (got.status !== want.status || got.violation !== want.violation ||
			got.vtag !== want.vtag || got.lspace !== want.lspace ||
			got.sspace !== want.sspace || got.tspace !== want.tspace) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: exp st %0d v %0d vt %h sp %0d/%0d/%0d",
					want.status, want.violation, want.vtag, want.lspace, want.sspace,
					want.tspace);
				$display("          got st %0d v %0d vt %h sp %0d/%0d/%0d",
					got.status, got.violation, got.vtag, got.lspace, got.sspace,
					got.tspace);
			end
		end
	endfunction
endclass

module load_store_queue_disambiguation_unit_test;

	localparam lsqd_pkg::req_t REQ_UNUSED = 3'd7;
	localparam int   STALL_LIMIT = 3000;
	localparam int   HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [lsqd_pkg::CFG_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	lsqd_req_if req ();
	lsqd_rsp_if rsp ();

	load_store_queue_disambiguation_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lsq_scoreboard lsq_sb;
	int          idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
	bit          long_hold;
	int          hold_off;
	bit          hold_seen;
	int          quiet_cycles;
	logic [63:0] next_tag;

	// clock
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// note accepted requests, check accepted results
	always @(posedge clk) begin
		lsq_beat_t   b;
		lsq_result_t g;
		if (req.valid && req.ready) begin
			b.op = req.req_type;
			b.tag = req.seq_tag;
			b.addr = req.access_addr;
			b.len = req.access_bytes;
			lsq_sb.note_request(b);
		end
		if (rsp.valid && rsp.ready) begin
			g.status = rsp.status;
			g.violation = rsp.violation;
			g.vtag = rsp.violating_tag;
			g.lspace = rsp.load_space;
			g.sspace = rsp.store_space;
			g.tspace = rsp.total_space;
			lsq_sb.check_result(g);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		rsp.ready = 0;
		hold_off = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_seen) begin
				hold_off = HOLD_CYCLES;
				hold_seen = 1;
			end
			if (hold_off > 0) begin
				hold_off--;
				rsp.ready <= 0;
			end else if (idle_mode >= 2) begin
				rsp.ready <= ($urandom_range(0, 99) >= 68);
			end else begin
				rsp.ready <= 1;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// a tag already held in one of the queues, or a random one
	function automatic logic [63:0] held_tag();
		int n;
		n = lsq_sb.loads.size() + lsq_sb.stores.size();
		if (n == 0) return rand64();
		n = $urandom_range(0, n - 1);
		if (n < lsq_sb.loads.size()) return lsq_sb.loads[n].tag;
		return lsq_sb.stores[n - lsq_sb.loads.size()].tag;
	endfunction

	function automatic lsq_beat_t random_beat();
		lsq_beat_t b;
		int        r;
		r = $urandom_range(0, 99);
		if (r < 24) b.op = lsqd_pkg::REQ_ADD_LOAD;
		else if (r < 44) b.op = lsqd_pkg::REQ_ADD_STORE;
		else if (r < 58) b.op = lsqd_pkg::REQ_LOAD_READY;
		else if (r < 64) b.op = lsqd_pkg::REQ_MARK_FLUSH;
		else if (r < 68) b.op = lsqd_pkg::REQ_PURGE;
		else if (r < 81) b.op = lsqd_pkg::REQ_COMMIT_LOAD;
		else if (r < 97) b.op = lsqd_pkg::REQ_COMMIT_STORE;
		else b.op = REQ_UNUSED;
		r = $urandom_range(0, 99);
		case (b.op)
			lsqd_pkg::REQ_ADD_LOAD, lsqd_pkg::REQ_ADD_STORE: begin
				if (r < 8) b.tag = rand64();
				else if (r < 15) b.tag = held_tag();
				else begin
					b.tag = next_tag;
					next_tag++;
				end
			end
			lsqd_pkg::REQ_COMMIT_LOAD:
				b.tag = (r < 85 && lsq_sb.loads.size() > 0) ? lsq_sb.loads[0].tag : held_tag();
			lsqd_pkg::REQ_COMMIT_STORE:
				b.tag = (r < 85 && lsq_sb.stores.size() > 0) ? lsq_sb.stores[0].tag : held_tag();
			default:
				b.tag = (r < 85) ? held_tag() : rand64();
		endcase
		r = $urandom_range(0, 99);
		if (r < 75) b.addr = 64'($urandom_range(0, 127));
		else if (r < 88) b.addr = rand64();
		else b.addr = 64'hFFFF_FFFF_FFFF_FF80 + 64'($urandom_range(0, 127));
		b.len = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 16)) :
			8'($urandom_range(0, 255));
		return b;
	endfunction

	// offer one request beat and wait until it is taken
	task automatic send(input bit rnd, input lsq_beat_t fixed);
		lsq_beat_t b;
		@(negedge clk);
		while ((idle_mode == 1 || idle_mode == 3) && $urandom_range(0, 99) < 68) begin
			req.valid <= 0;
			@(negedge clk);
		end
		b = rnd ? random_beat() : fixed;
		req.valid <= 1;
		req.req_type <= b.op;
		req.seq_tag <= b.tag;
		req.access_addr <= b.addr;
		req.access_bytes <= b.len;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_fixed(input lsqd_pkg::req_t op, input logic [63:0] tag,
		input logic [63:0] addr, input logic [7:0] len);
		lsq_beat_t b;
		b.op = op;
		b.tag = tag;
		b.addr = addr;
		b.len = len;
		send(0, b);
	endtask

	task automatic send_random(input int n);
		lsq_beat_t b;
		repeat (n) send(1, b);
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		@(negedge clk);
		req.valid <= 0;
		while (lsq_sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic reg_write(input lsqd_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= lsqd_pkg::CFG_AW'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic configure(input bit mode, input int cc, input int lc, input int sc);
		reg_write(lsqd_pkg::REG_COMBINED_MODE, 32'(mode));
		reg_write(lsqd_pkg::REG_COMBINED_CAP, 32'(cc));
		reg_write(lsqd_pkg::REG_LOAD_CAP, 32'(lc));
		reg_write(lsqd_pkg::REG_STORE_CAP, 32'(sc));
		lsq_sb.cmode = mode;
		lsq_sb.ccap = cc;
		lsq_sb.lcap = lc;
		lsq_sb.scap = sc;
	endtask

	initial begin
		lsq_sb = new();
		lsq_sb.clear();
		idle_mode = 0;
		long_hold = 0;
		next_tag = 64'd1;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		req.valid = 0;
		req.req_type = lsqd_pkg::REQ_PURGE;
		req.seq_tag = '0;
		req.access_addr = '0;
		req.access_bytes = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty queue, not found, unknown request, extremes, overlaps
		send_fixed(lsqd_pkg::REQ_COMMIT_LOAD, 64'd5, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_STORE, 64'd5, 0, 0);
		send_fixed(lsqd_pkg::REQ_LOAD_READY, 64'd5, 0, 0);
		send_fixed(lsqd_pkg::REQ_MARK_FLUSH, 64'd5, 0, 0);
		send_fixed(lsqd_pkg::REQ_PURGE, 0, 0, 0);
		send_fixed(REQ_UNUSED, '1, '1, '1);
		send_fixed(lsqd_pkg::REQ_ADD_LOAD, 64'd0, 64'd0, 8'd0);
		send_fixed(lsqd_pkg::REQ_ADD_LOAD, '1, '1, 8'hFF);
		send_fixed(lsqd_pkg::REQ_ADD_LOAD, 64'd10, 64'd100, 8'd8);
		send_fixed(lsqd_pkg::REQ_LOAD_READY, '1, 0, 0);
		send_fixed(lsqd_pkg::REQ_LOAD_READY, 64'd10, 0, 0);
		send_fixed(lsqd_pkg::REQ_ADD_STORE, 64'd20, 64'd104, 8'd0);
		send_fixed(lsqd_pkg::REQ_ADD_STORE, 64'd21, 64'hFFFF_FFFF_FFFF_FFF0, 8'd200);
		send_fixed(lsqd_pkg::REQ_ADD_STORE, 64'd22, 64'd108, 8'd4);
		send_fixed(lsqd_pkg::REQ_COMMIT_STORE, 64'd21, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_STORE, 64'd20, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_STORE, 64'd21, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_STORE, 64'd22, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_LOAD, 64'd7, 0, 0);
		send_fixed(lsqd_pkg::REQ_MARK_FLUSH, '1, 0, 0);
		send_fixed(lsqd_pkg::REQ_PURGE, 0, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_LOAD, 64'd0, 0, 0);
		send_fixed(lsqd_pkg::REQ_COMMIT_LOAD, 64'd10, 0, 0);
		send_random(230);
		drain();

		configure(1, 64, 32, 32);
		idle_mode = 1;
		send_random(250);
		drain();

		configure(0, 0, 32, 32);
		idle_mode = 2;
		send_random(250);
		drain();

		configure(0, 5, 0, 5);
		idle_mode = 3;
		send_random(200);
		drain();

		configure(1, 0, 1, 1);
		idle_mode = 0;
		send_random(100);
		drain();

		// long receiver hold-off while requests keep coming
		configure(0, 64, 3, 32);
		idle_mode = 1;
		long_hold = 1;
		send_random(200);
		drain();

		configure(1, 7, 16, 16);
		idle_mode = 2;
		send_random(250);
		drain();

		configure(0, 33, 16, 1);
		idle_mode = 3;
		send_random(200);
		drain();

		if (lsq_sb.errors == 0 && lsq_sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

FILE: load_store_queue_disambiguation_unit.f
rtl/lsqd_pkg.sv
rtl/lsqd_if.sv
rtl/lsqd_cell.sv
rtl/load_store_queue_disambiguation_unit.sv
rtl/lsqd_checker.sv
tb/load_store_queue_disambiguation_unit_test.sv
